// ----- design/tpfs_pkg.sv -----
// Shared widths and command codes for the timed PWM fade switch.
package tpfs_pkg;

	localparam int FUNC_W  = 3;
	localparam int DUR_W   = 32;
	localparam int RAMP_W  = 16;
	localparam int LEVEL_W = 11;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK          = 3'd0,
		FN_ON            = 3'd1,
		FN_OFF           = 3'd2,
		FN_TOGGLE        = 3'd3,
		FN_TIMED_ON      = 3'd4,
		FN_FADE_ON       = 3'd5,
		FN_TIMED_FADE_ON = 3'd6
	} func_t;

endpackage

// ----- design/timed_pwm_fade_switch_top.sv -----
// Timed PWM fade switch: command decode, hold timer and bit-serial fade divider.
//
// Each accepted item gives exactly one result. Commands, the unused code and ticks that need
// no new fade level pass through the execute and emit steps before the next accept. A tick
// inside a fade-up or fade-down computes FULL_SCALE*x/ramp with a restoring divider that
// retires one quotient bit per cycle; the tick passes through the execute, multiply, divide
// and emit steps. A new item is taken while the previous result still waits in the output
// register; the result of that item is held back until the register frees.
// pin_level carries the low 11 bits of the drive level; pin_high is set whenever the full
// drive level is nonzero. The polarity register is written through the cfg channel, which
// is always ready.
module timed_pwm_fade_switch_top #(
	parameter int FULL_SCALE = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tpfs_pkg::FUNC_W-1:0]      func,
	input  logic [tpfs_pkg::DUR_W-1:0]       duration_ms,
	input  logic [tpfs_pkg::RAMP_W-1:0]      ramp_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tpfs_pkg::LEVEL_W-1:0]     pin_level,
	output logic                             pin_high
);

	localparam int DW    = tpfs_pkg::DUR_W;
	localparam int RW    = tpfs_pkg::RAMP_W;
	localparam int OW    = tpfs_pkg::LEVEL_W;
	localparam int LW    = $clog2(FULL_SCALE + 1);
	localparam int QW    = $clog2(FULL_SCALE);
	localparam int PW    = LW + RW;
	localparam int CW    = $clog2(QW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                state_q;
	tpfs_pkg::func_t       func_q;
	logic [DW-1:0]         dur_q;
	logic [RW-1:0]         ramp_in_q;
	logic                  invert_q;
	logic [DW-1:0]         elapsed_q;
	logic [DW-1:0]         hold_q;
	logic [RW-1:0]         ramp_len_q;
	logic [LW-1:0]         drive_q;
	logic                  fading_up_q;
	logic                  timed_q;
	logic                  fading_down_q;
	logic [RW-1:0]         x_q;
	logic [RW-1:0]         rem_q;
	logic [QW-1:0]         qr_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;
	logic [OW-1:0]         pin_level_q;
	logic                  pin_high_q;

	logic [DW-1:0]         elapsed_inc;
	logic [DW-1:0]         fade_start;
	logic                  is_high;
	logic [LW-1:0]         on_val;
	logic [LW-1:0]         off_val;
	logic [LW-1:0]         full_val;
	logic [PW-1:0]         prod;
	logic [RW:0]           trial;
	logic [RW:0]           diff;
	logic                  q_bit;
	logic [QW-1:0]         qr_next;
	logic                  up_div;
	logic                  down_div;

	assign full_val    = LW'(FULL_SCALE);
	assign is_high     = (drive_q != '0);
	assign on_val      = invert_q ? '0 : full_val;
	assign off_val     = invert_q ? full_val : '0;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + DW'(1);
	assign fade_start  = (hold_q > DW'(ramp_len_q)) ? hold_q - DW'(ramp_len_q) : '0;
	assign prod        = PW'(full_val) * PW'(x_q);
	assign trial       = {rem_q, qr_q[QW-1]};
	assign diff        = trial - {1'b0, ramp_len_q};
	assign q_bit       = ~diff[RW];
	assign qr_next     = {qr_q[QW-2:0], q_bit};
	assign up_div      = fading_up_q && (elapsed_inc < DW'(ramp_len_q));
	assign down_div    = !fading_up_q && timed_q && !(elapsed_inc > hold_q) &&
		fading_down_q && is_high && (elapsed_inc > fade_start) && (ramp_len_q != '0);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pin_level = pin_level_q;
	assign pin_high  = pin_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			invert_q      <= 1'b0;
			elapsed_q     <= '0;
			hold_q        <= '0;
			ramp_len_q    <= '0;
			drive_q       <= '0;
			fading_up_q   <= 1'b0;
			timed_q       <= 1'b0;
			fading_down_q <= 1'b0;
			out_valid_q   <= 1'b0;
			func_q        <= tpfs_pkg::FN_TICK;
			dur_q         <= '0;
			ramp_in_q     <= '0;
			x_q           <= '0;
			rem_q         <= '0;
			qr_q          <= '0;
			cnt_q         <= '0;
			pin_level_q   <= '0;
			pin_high_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				invert_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q    <= tpfs_pkg::func_t'(func);
						dur_q     <= duration_ms;
						ramp_in_q <= ramp_ms;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= (func_q == tpfs_pkg::FN_TICK && (up_div || down_div)) ?
						ST_MUL : ST_EMIT;
					case (func_q)
						tpfs_pkg::FN_TICK: begin
							elapsed_q <= elapsed_inc;
							if (fading_up_q) begin
								if (elapsed_inc < DW'(ramp_len_q)) begin
									x_q <= RW'(elapsed_inc);
								end else begin
									fading_up_q <= 1'b0;
									drive_q     <= on_val;
								end
							end else if (timed_q) begin
								if (elapsed_inc > hold_q) begin
									drive_q       <= off_val;
									timed_q       <= 1'b0;
									fading_down_q <= 1'b0;
								end else if (fading_down_q && is_high &&
									elapsed_inc > fade_start && ramp_len_q != '0) begin
									x_q <= RW'(hold_q - elapsed_inc);
								end
							end
						end
						tpfs_pkg::FN_ON: drive_q <= on_val;
						tpfs_pkg::FN_OFF: drive_q <= off_val;
						tpfs_pkg::FN_TOGGLE: drive_q <= is_high ? '0 : full_val;
						tpfs_pkg::FN_TIMED_ON: begin
							if (!is_high) begin
								elapsed_q <= '0;
								hold_q    <= dur_q;
								drive_q   <= on_val;
								timed_q   <= 1'b1;
							end
						end
						tpfs_pkg::FN_FADE_ON: begin
							if (!is_high && !fading_up_q) begin
								fading_up_q <= 1'b1;
								elapsed_q   <= '0;
								ramp_len_q  <= ramp_in_q;
							end
						end
						tpfs_pkg::FN_TIMED_FADE_ON: begin
							if (!is_high) begin
								if (!fading_up_q) begin
									fading_up_q <= 1'b1;
									elapsed_q   <= '0;
									ramp_len_q  <= ramp_in_q;
								end
								hold_q        <= dur_q;
								timed_q       <= 1'b1;
								fading_down_q <= 1'b1;
							end else if (!fading_up_q) begin
								hold_q    <= dur_q;
								elapsed_q <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					rem_q   <= RW'(prod[PW-1:QW]);
					qr_q    <= prod[QW-1:0];
					cnt_q   <= CW'(QW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= q_bit ? diff[RW-1:0] : trial[RW-1:0];
					qr_q  <= qr_next;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						drive_q <= LW'(qr_next);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						pin_level_q <= OW'(drive_q);
						pin_high_q  <= is_high;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> ramp_len_q != '0)
		else $error("fade divider running with zero ramp");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q <= full_val)
		else $error("drive level above full scale");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the timed PWM fade switch: directed and random command/tick streams.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FULL_SCALE = 1024;
	localparam logic [tpfs_pkg::FUNC_W-1:0] FN_SPARE = 3'd7;

	typedef struct packed {
		logic [tpfs_pkg::LEVEL_W-1:0] level;
		logic                         high;
	} light_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_data = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [tpfs_pkg::FUNC_W-1:0]   func = tpfs_pkg::FN_TICK;
	logic [tpfs_pkg::DUR_W-1:0]    duration_ms = '0;
	logic [tpfs_pkg::RAMP_W-1:0]   ramp_ms = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [tpfs_pkg::LEVEL_W-1:0]  pin_level;
	logic                          pin_high;

	light_result_t expected_lights[$];
	light_result_t oldest_light;
	int            mismatches = 0;
	int            items_sent = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;

	logic [31:0] lit_level;
	logic [31:0] ms_elapsed;
	logic [31:0] ms_hold;
	logic [15:0] ms_ramp;
	logic        ramping_up;
	logic        hold_running;
	logic        ramping_down;
	logic        invert_pol;

	timed_pwm_fade_switch_top #(
		.FULL_SCALE(FULL_SCALE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.duration_ms(duration_ms),
		.ramp_ms(ramp_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pin_level(pin_level),
		.pin_high(pin_high)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] on_level();
		return invert_pol ? 32'd0 : 32'(FULL_SCALE);
	endfunction

	function automatic logic [31:0] off_level();
		return invert_pol ? 32'(FULL_SCALE) : 32'd0;
	endfunction

	function automatic void begin_fade_up(input logic [15:0] ramp);
		if (lit_level == '0 && !ramping_up) begin
			ramping_up = 1'b1;
			ms_elapsed = '0;
			ms_ramp = ramp;
		end
	endfunction

	function automatic void advance_ms();
		longint unsigned fs;
		longint unsigned prod;
		logic [31:0]     fade_start;
		fs = 64'(FULL_SCALE);
		if (ms_elapsed != '1)
			ms_elapsed = ms_elapsed + 32'd1;
		if (ramping_up) begin
			if (ms_elapsed < {16'd0, ms_ramp}) begin
				prod = fs * 64'(ms_elapsed);
				lit_level = 32'(prod / 64'(ms_ramp));
			end else begin
				ramping_up = 1'b0;
				lit_level = on_level();
			end
		end else if (hold_running) begin
			if (ms_elapsed > ms_hold) begin
				lit_level = off_level();
				hold_running = 1'b0;
				ramping_down = 1'b0;
			end else if (ramping_down && lit_level != '0) begin
				fade_start = (ms_hold > {16'd0, ms_ramp}) ?
					ms_hold - {16'd0, ms_ramp} : 32'd0;
				if (ms_elapsed > fade_start && ms_ramp != '0) begin
					prod = fs * 64'(ms_hold - ms_elapsed);
					lit_level = 32'(prod / 64'(ms_ramp));
				end
			end
		end
	endfunction

	function automatic light_result_t predict_light(input logic [tpfs_pkg::FUNC_W-1:0] code,
			input logic [31:0] dur, input logic [15:0] ramp);
		light_result_t res;
		case (code)
			tpfs_pkg::FN_TICK: begin
				advance_ms();
			end
			tpfs_pkg::FN_ON: begin
				lit_level = on_level();
			end
			tpfs_pkg::FN_OFF: begin
				lit_level = off_level();
			end
			tpfs_pkg::FN_TOGGLE: begin
				lit_level = (lit_level != '0) ? 32'd0 : 32'(FULL_SCALE);
			end
			tpfs_pkg::FN_TIMED_ON: begin
				if (lit_level == '0) begin
					ms_elapsed = '0;
					ms_hold = dur;
					lit_level = on_level();
					hold_running = 1'b1;
				end
			end
			tpfs_pkg::FN_FADE_ON: begin
				begin_fade_up(ramp);
			end
			tpfs_pkg::FN_TIMED_FADE_ON: begin
				if (lit_level == '0) begin
					begin_fade_up(ramp);
					ms_hold = dur;
					hold_running = 1'b1;
					ramping_down = 1'b1;
				end else if (!ramping_up) begin
					ms_hold = dur;
					ms_elapsed = '0;
				end
			end
			default: begin
			end
		endcase
		res.level = lit_level[tpfs_pkg::LEVEL_W-1:0];
		res.high = (lit_level != '0);
		return res;
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_lights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: level %0d high %0b", pin_level, pin_high);
			end else begin
				oldest_light = expected_lights.pop_front();
				if (pin_level !== oldest_light.level || pin_high !== oldest_light.high) begin
					mismatches++;
					if (mismatches <= 10)
						$display("light mismatch: level exp %0d got %0d, high exp %0b got %0b",
							oldest_light.level, pin_level, oldest_light.high, pin_high);
				end
			end
		end
	end

	task automatic send_item(input logic [tpfs_pkg::FUNC_W-1:0] code, input logic [31:0] dur,
			input logic [15:0] ramp);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= code;
		duration_ms <= dur;
		ramp_ms <= ramp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_lights.push_back(predict_light(code, dur, ramp));
		items_sent++;
	endtask

	task automatic drain_lights();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_lights.size() != 0) @(posedge clk);
	endtask

	task automatic set_polarity(input logic value);
		drain_lights();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		invert_pol = value;
	endtask

	task automatic send_noise();
		logic [tpfs_pkg::FUNC_W-1:0] code;
		logic [31:0]                 dur;
		logic [15:0]                 ramp;
		code = tpfs_pkg::FUNC_W'($urandom_range(0, 7));
		dur = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
		if (code == tpfs_pkg::FN_FADE_ON || code == tpfs_pkg::FN_TIMED_FADE_ON)
			ramp = 16'($urandom_range(0, 40));
		else
			ramp = 16'($urandom_range(0, 65535));
		send_item(code, dur, ramp);
	endtask

	task automatic run_light_cycle();
		logic [tpfs_pkg::FUNC_W-1:0] code;
		logic [31:0]                 dur;
		logic [15:0]                 ramp;
		int                          ticks;
		if (lit_level != '0)
			send_item(tpfs_pkg::FN_TOGGLE, $urandom, 16'($urandom));
		case ($urandom_range(0, 3))
			0: code = tpfs_pkg::FN_TIMED_ON;
			1: code = tpfs_pkg::FN_FADE_ON;
			default: code = tpfs_pkg::FN_TIMED_FADE_ON;
		endcase
		dur = $urandom_range(0, 30);
		ramp = 16'($urandom_range(0, 24));
		send_item(code, dur, ramp);
		ticks = dur + ramp + $urandom_range(1, 4);
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 99) < 8)
				send_noise();
			else
				send_item(tpfs_pkg::FN_TICK, $urandom, 16'($urandom));
		end
	endtask

	task automatic test_directed();
		send_item(tpfs_pkg::FN_TICK, '0, '0);
		send_item(FN_SPARE, '1, '1);
		send_item(tpfs_pkg::FN_ON, '0, '0);
		send_item(tpfs_pkg::FN_TIMED_ON, '1, '1);
		send_item(tpfs_pkg::FN_OFF, '0, '0);
		send_item(tpfs_pkg::FN_TOGGLE, '0, '0);
		send_item(tpfs_pkg::FN_TOGGLE, '0, '0);
		send_item(tpfs_pkg::FN_TIMED_ON, 32'd1, '0);
		send_item(tpfs_pkg::FN_TICK, '0, '0);
		send_item(tpfs_pkg::FN_TICK, '0, '0);
		send_item(tpfs_pkg::FN_FADE_ON, '0, 16'd0);
		send_item(tpfs_pkg::FN_TICK, '0, '0);
		send_item(tpfs_pkg::FN_TOGGLE, '0, '0);
		send_item(tpfs_pkg::FN_TIMED_FADE_ON, 32'd7, 16'd4);
		repeat (4) send_item(tpfs_pkg::FN_TICK, '0, '0);
		// ramp now longer than the restarted hold
		send_item(tpfs_pkg::FN_TIMED_FADE_ON, 32'd2, 16'hFFFF);
		repeat (3) send_item(tpfs_pkg::FN_TICK, '0, '0);
		send_item(tpfs_pkg::FN_TIMED_FADE_ON, 32'd1, 16'd0);
		repeat (2) send_item(tpfs_pkg::FN_TICK, '0, '0);
		drain_lights();
	endtask

	task automatic test_polarity();
		set_polarity(1'b1);
		send_item(tpfs_pkg::FN_ON, '0, '0);
		send_item(tpfs_pkg::FN_OFF, '0, '0);
		send_item(tpfs_pkg::FN_TOGGLE, '0, '0);
		send_item(tpfs_pkg::FN_TIMED_ON, 32'd1, '0);
		repeat (2) send_item(tpfs_pkg::FN_TICK, '0, '0);
		send_item(tpfs_pkg::FN_FADE_ON, '0, 16'd2);
		send_item(tpfs_pkg::FN_TOGGLE, '0, '0);
		send_item(tpfs_pkg::FN_FADE_ON, '0, 16'd2);
		repeat (2) send_item(tpfs_pkg::FN_TICK, '0, '0);
		drain_lights();
	endtask

	task automatic test_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 60)
				run_light_cycle();
			else
				send_noise();
			if ($urandom_range(0, 99) < 3)
				drain_lights();
		end
		drain_lights();
	endtask

	initial begin
		lit_level = '0;
		ms_elapsed = '0;
		ms_hold = '0;
		ms_ramp = '0;
		ramping_up = 1'b0;
		hold_running = 1'b0;
		ramping_down = 1'b0;
		invert_pol = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 78;
		test_directed();
		test_random(230);

		send_idle_pct = 78;
		recv_idle_pct = 30;
		test_polarity();
		test_random(230);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_polarity(1'b0);
		test_random(240);

		repeat (30) @(posedge clk);
		if (expected_lights.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", expected_lights.size());
		end
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/tpfs_pkg.sv
design/timed_pwm_fade_switch_top.sv
tb/tb.sv
